/* sv/cssw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cssw_pkg;
    localparam int COORD_BITS_DEF = 11;
    localparam int RSQ_BITS       = 20;
    localparam int FRAC_BITS      = 16;
    localparam int FRAC_SHIFT     = 2;
    localparam int OUT_BITS       = 16;
    localparam int NO_HIT         = 16384;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        FRAC_ZERO,
        FRAC_ONE,
        FRAC_DIV
    } frac_mode_t;

    // width of the determinant-level signed words
    function automatic int wide_bits(input int coord_bits);
        return 4 * coord_bits + 8;
    endfunction
endpackage
`default_nettype wire

/* sv/capsule_segment_sweep_test_top.sv */
// Capsule sweep test: closest points between a path segment and a wall.
// Input channel (in_valid/in_ready) carries one test per beat: path start
// and end, wall start and end, and the squared radius. Output channel
// (out_valid/out_ready) returns one beat per test: hit, and hit_fraction,
// the path parameter over four minus one, or 16384 on a miss.
// Throughput: one test per cycle while the output is taken.
// Pipeline order with no stall: seven front stages (differences, dot
// products, determinant products, clamps, fraction classing), the queue,
// sixteen stages of the restoring dividers (one quotient bit each), and
// four stages of offset products, floor, squares and threshold compare.
// A four-entry queue sits between front and back; when the receiver
// stalls the back freezes, the queue fills, then the front freezes and
// in_ready drops. Results come out in input order.
// Reset (rst_n, asynchronous, active low) empties the pipeline and queue;
// the block takes a beat in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module capsule_segment_sweep_test_top #(
    parameter int COORD_BITS = cssw_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [COORD_BITS-1:0]             path_start_x,
    input  wire logic [COORD_BITS-1:0]             path_start_y,
    input  wire logic [COORD_BITS-1:0]             path_end_x,
    input  wire logic [COORD_BITS-1:0]             path_end_y,
    input  wire logic [COORD_BITS-1:0]             wall_start_x,
    input  wire logic [COORD_BITS-1:0]             wall_start_y,
    input  wire logic [COORD_BITS-1:0]             wall_end_x,
    input  wire logic [COORD_BITS-1:0]             wall_end_y,
    input  wire logic [cssw_pkg::RSQ_BITS-1:0]     radius_squared,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   hit,
    output logic signed [cssw_pkg::OUT_BITS-1:0]   hit_fraction
);
    import cssw_pkg::*;

    localparam int DW = wide_bits(COORD_BITS);
    localparam int CW = COORD_BITS + 1;
    localparam int QW = 4 + 4 * DW + 6 * CW + RSQ_BITS;

    logic                 f_valid, f_ready;
    frac_mode_t           f_s_mode, f_t_mode;
    logic signed [DW-1:0] f_sn, f_sd, f_tn, f_td;
    logic signed [CW-1:0] f_ux, f_uy, f_vx, f_vy, f_wx, f_wy;
    logic [RSQ_BITS-1:0]  f_rsq;

    logic                 q_valid, q_ready;
    logic [QW-1:0]        q_in, q_out;
    logic [1:0]           q_s_mode, q_t_mode;
    logic signed [DW-1:0] q_sn, q_sd, q_tn, q_td;
    logic signed [CW-1:0] q_ux, q_uy, q_vx, q_vy, q_wx, q_wy;
    logic [RSQ_BITS-1:0]  q_rsq;

    cssw_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .path_start_x   (path_start_x),
        .path_start_y   (path_start_y),
        .path_end_x     (path_end_x),
        .path_end_y     (path_end_y),
        .wall_start_x   (wall_start_x),
        .wall_start_y   (wall_start_y),
        .wall_end_x     (wall_end_x),
        .wall_end_y     (wall_end_y),
        .radius_squared (radius_squared),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .out_s_mode     (f_s_mode),
        .out_t_mode     (f_t_mode),
        .out_sn         (f_sn),
        .out_sd         (f_sd),
        .out_tn         (f_tn),
        .out_td         (f_td),
        .out_ux         (f_ux),
        .out_uy         (f_uy),
        .out_vx         (f_vx),
        .out_vy         (f_vy),
        .out_wx         (f_wx),
        .out_wy         (f_wy),
        .out_rsq        (f_rsq)
    );

    assign q_in = {f_s_mode, f_t_mode, f_sn, f_sd, f_tn, f_td,
                   f_ux, f_uy, f_vx, f_vy, f_wx, f_wy, f_rsq};

    cssw_fifo #(.WIDTH(QW)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out)
    );

    assign {q_s_mode, q_t_mode, q_sn, q_sd, q_tn, q_td,
            q_ux, q_uy, q_vx, q_vy, q_wx, q_wy, q_rsq} = q_out;

    cssw_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_s_mode    (frac_mode_t'(q_s_mode)),
        .in_t_mode    (frac_mode_t'(q_t_mode)),
        .in_sn        (q_sn),
        .in_sd        (q_sd),
        .in_tn        (q_tn),
        .in_td        (q_td),
        .in_ux        (q_ux),
        .in_uy        (q_uy),
        .in_vx        (q_vx),
        .in_vy        (q_vy),
        .in_wx        (q_wx),
        .in_wy        (q_wy),
        .in_rsq       (q_rsq),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .hit_fraction (hit_fraction)
    );
endmodule
`default_nettype wire

/* sv/cssw_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module cssw_front #(
    parameter int COORD_BITS = cssw_pkg::COORD_BITS_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire logic [COORD_BITS-1:0]                         path_start_x,
    input  wire logic [COORD_BITS-1:0]                         path_start_y,
    input  wire logic [COORD_BITS-1:0]                         path_end_x,
    input  wire logic [COORD_BITS-1:0]                         path_end_y,
    input  wire logic [COORD_BITS-1:0]                         wall_start_x,
    input  wire logic [COORD_BITS-1:0]                         wall_start_y,
    input  wire logic [COORD_BITS-1:0]                         wall_end_x,
    input  wire logic [COORD_BITS-1:0]                         wall_end_y,
    input  wire logic [cssw_pkg::RSQ_BITS-1:0]                 radius_squared,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output cssw_pkg::frac_mode_t                               out_s_mode,
    output cssw_pkg::frac_mode_t                               out_t_mode,
    output logic signed [cssw_pkg::wide_bits(COORD_BITS)-1:0]  out_sn,
    output logic signed [cssw_pkg::wide_bits(COORD_BITS)-1:0]  out_sd,
    output logic signed [cssw_pkg::wide_bits(COORD_BITS)-1:0]  out_tn,
    output logic signed [cssw_pkg::wide_bits(COORD_BITS)-1:0]  out_td,
    output logic signed [COORD_BITS:0]                         out_ux,
    output logic signed [COORD_BITS:0]                         out_uy,
    output logic signed [COORD_BITS:0]                         out_vx,
    output logic signed [COORD_BITS:0]                         out_vy,
    output logic signed [COORD_BITS:0]                         out_wx,
    output logic signed [COORD_BITS:0]                         out_wy,
    output logic [cssw_pkg::RSQ_BITS-1:0]                      out_rsq
);
    import cssw_pkg::*;

    localparam int CW  = COORD_BITS + 1;
    localparam int DW2 = 2 * COORD_BITS + 3;
    localparam int DW  = wide_bits(COORD_BITS);
    localparam int NST = 7;

    logic             en;
    logic [NST-1:0]   v_reg;

    // stage 1: differences
    logic signed [CW-1:0] s1_ux_reg, s1_uy_reg, s1_vx_reg, s1_vy_reg, s1_wx_reg, s1_wy_reg;
    logic [RSQ_BITS-1:0]  s1_rsq_reg;
    // stage 2: dot products
    logic signed [DW2-1:0] a_next, b_next, c_next, d_next, e_next;
    logic signed [DW2-1:0] s2_a_reg, s2_b_reg, s2_c_reg, s2_d_reg, s2_e_reg;
    logic signed [CW-1:0]  s2_ux_reg, s2_uy_reg, s2_vx_reg, s2_vy_reg, s2_wx_reg, s2_wy_reg;
    logic [RSQ_BITS-1:0]   s2_rsq_reg;
    // stage 3: products of dots
    logic signed [DW-1:0]  ac_next, bb_next, be_next, cd_next, ae_next, bd_next;
    logic signed [DW-1:0]  s3_ac_reg, s3_bb_reg, s3_be_reg, s3_cd_reg, s3_ae_reg, s3_bd_reg;
    logic signed [DW2-1:0] s3_a_reg, s3_b_reg, s3_c_reg, s3_d_reg, s3_e_reg;
    logic signed [CW-1:0]  s3_ux_reg, s3_uy_reg, s3_vx_reg, s3_vy_reg, s3_wx_reg, s3_wy_reg;
    logic [RSQ_BITS-1:0]   s3_rsq_reg;
    // stage 4: determinant, raw numerators, edge compares
    logic signed [DW2:0]   nd_next, bmd_next;
    logic signed [DW-1:0]  s4_det_reg, s4_sn_reg, s4_tn_reg;
    logic signed [DW2-1:0] s4_a_reg, s4_b_reg, s4_c_reg, s4_e_reg;
    logic signed [DW2:0]   s4_nd_reg, s4_bmd_reg;
    logic                  s4_nd_lt0_reg, s4_nd_gt_a_reg, s4_bmd_lt0_reg, s4_bmd_gt_a_reg;
    logic signed [CW-1:0]  s4_ux_reg, s4_uy_reg, s4_vx_reg, s4_vy_reg, s4_wx_reg, s4_wy_reg;
    logic [RSQ_BITS-1:0]   s4_rsq_reg;
    // stage 5: path clamp
    logic signed [DW-1:0]  sn5_next, sd5_next, tn5_next, td5_next;
    logic signed [DW-1:0]  s5_sn_reg, s5_sd_reg, s5_tn_reg, s5_td_reg;
    logic signed [DW2-1:0] s5_a_reg;
    logic signed [DW2:0]   s5_nd_reg, s5_bmd_reg;
    logic                  s5_nd_lt0_reg, s5_nd_gt_a_reg, s5_bmd_lt0_reg, s5_bmd_gt_a_reg;
    logic signed [CW-1:0]  s5_ux_reg, s5_uy_reg, s5_vx_reg, s5_vy_reg, s5_wx_reg, s5_wy_reg;
    logic [RSQ_BITS-1:0]   s5_rsq_reg;
    // stage 6: wall clamp
    logic signed [DW-1:0]  sn6_next, sd6_next, tn6_next, td6_next;
    logic signed [DW-1:0]  s6_sn_reg, s6_sd_reg, s6_tn_reg, s6_td_reg;
    logic signed [CW-1:0]  s6_ux_reg, s6_uy_reg, s6_vx_reg, s6_vy_reg, s6_wx_reg, s6_wy_reg;
    logic [RSQ_BITS-1:0]   s6_rsq_reg;
    // stage 7: fraction mode
    frac_mode_t            s_mode_next, t_mode_next;
    frac_mode_t            s7_s_mode_reg, s7_t_mode_reg;
    logic signed [DW-1:0]  s7_sn_reg, s7_sd_reg, s7_tn_reg, s7_td_reg;
    logic signed [CW-1:0]  s7_ux_reg, s7_uy_reg, s7_vx_reg, s7_vy_reg, s7_wx_reg, s7_wy_reg;
    logic [RSQ_BITS-1:0]   s7_rsq_reg;

    // advance the whole front together unless its last beat is blocked
    assign en       = !v_reg[NST-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    assign a_next = s1_ux_reg * s1_ux_reg + s1_uy_reg * s1_uy_reg;
    assign b_next = s1_ux_reg * s1_vx_reg + s1_uy_reg * s1_vy_reg;
    assign c_next = s1_vx_reg * s1_vx_reg + s1_vy_reg * s1_vy_reg;
    assign d_next = s1_ux_reg * s1_wx_reg + s1_uy_reg * s1_wy_reg;
    assign e_next = s1_vx_reg * s1_wx_reg + s1_vy_reg * s1_wy_reg;

    assign ac_next = s2_a_reg * s2_c_reg;
    assign bb_next = s2_b_reg * s2_b_reg;
    assign be_next = s2_b_reg * s2_e_reg;
    assign cd_next = s2_c_reg * s2_d_reg;
    assign ae_next = s2_a_reg * s2_e_reg;
    assign bd_next = s2_b_reg * s2_d_reg;

    assign nd_next  = -(DW2 + 1)'(s3_d_reg);
    assign bmd_next = (DW2 + 1)'(s3_b_reg) - (DW2 + 1)'(s3_d_reg);

    always_comb begin
        sn5_next = s4_sn_reg;
        sd5_next = s4_det_reg;
        tn5_next = s4_tn_reg;
        td5_next = s4_det_reg;
        // parallel or degenerate: start the path at zero
        priority if (s4_det_reg <= 0) begin
            sn5_next = '0;
            sd5_next = DW'(1);
            tn5_next = DW'(s4_e_reg);
            td5_next = DW'(s4_c_reg);
        end
        else if (s4_sn_reg < 0) begin
            sn5_next = '0;
            tn5_next = DW'(s4_e_reg);
            td5_next = DW'(s4_c_reg);
        end
        else if (s4_sn_reg > s4_det_reg) begin
            sn5_next = s4_det_reg;
            tn5_next = DW'(s4_e_reg) + DW'(s4_b_reg);
            td5_next = DW'(s4_c_reg);
        end
        else begin
            sn5_next = s4_sn_reg;
        end
    end

    always_comb begin
        sn6_next = s5_sn_reg;
        sd6_next = s5_sd_reg;
        tn6_next = s5_tn_reg;
        td6_next = s5_td_reg;
        priority if (s5_tn_reg < 0) begin
            tn6_next = '0;
            priority if (s5_nd_lt0_reg) begin
                sn6_next = '0;
            end
            else if (s5_nd_gt_a_reg) begin
                sn6_next = s5_sd_reg;
            end
            else begin
                sn6_next = DW'(s5_nd_reg);
                sd6_next = DW'(s5_a_reg);
            end
        end
        else if (s5_tn_reg > s5_td_reg) begin
            tn6_next = s5_td_reg;
            priority if (s5_bmd_lt0_reg) begin
                sn6_next = '0;
            end
            else if (s5_bmd_gt_a_reg) begin
                sn6_next = s5_sd_reg;
            end
            else begin
                sn6_next = DW'(s5_bmd_reg);
                sd6_next = DW'(s5_a_reg);
            end
        end
        else begin
            tn6_next = s5_tn_reg;
        end
    end

    always_comb begin
        priority if (s6_sn_reg <= 0 || s6_sd_reg <= 0) begin
            s_mode_next = FRAC_ZERO;
        end
        else if (s6_sn_reg >= s6_sd_reg) begin
            s_mode_next = FRAC_ONE;
        end
        else begin
            s_mode_next = FRAC_DIV;
        end
        priority if (s6_tn_reg <= 0 || s6_td_reg <= 0) begin
            t_mode_next = FRAC_ZERO;
        end
        else if (s6_tn_reg >= s6_td_reg) begin
            t_mode_next = FRAC_ONE;
        end
        else begin
            t_mode_next = FRAC_DIV;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s1_ux_reg  <= $signed({1'b0, path_end_x}) - $signed({1'b0, path_start_x});
            s1_uy_reg  <= $signed({1'b0, path_end_y}) - $signed({1'b0, path_start_y});
            s1_vx_reg  <= $signed({1'b0, wall_end_x}) - $signed({1'b0, wall_start_x});
            s1_vy_reg  <= $signed({1'b0, wall_end_y}) - $signed({1'b0, wall_start_y});
            s1_wx_reg  <= $signed({1'b0, path_start_x}) - $signed({1'b0, wall_start_x});
            s1_wy_reg  <= $signed({1'b0, path_start_y}) - $signed({1'b0, wall_start_y});
            s1_rsq_reg <= radius_squared;

            s2_a_reg   <= a_next;
            s2_b_reg   <= b_next;
            s2_c_reg   <= c_next;
            s2_d_reg   <= d_next;
            s2_e_reg   <= e_next;
            s2_ux_reg  <= s1_ux_reg;
            s2_uy_reg  <= s1_uy_reg;
            s2_vx_reg  <= s1_vx_reg;
            s2_vy_reg  <= s1_vy_reg;
            s2_wx_reg  <= s1_wx_reg;
            s2_wy_reg  <= s1_wy_reg;
            s2_rsq_reg <= s1_rsq_reg;

            s3_ac_reg  <= ac_next;
            s3_bb_reg  <= bb_next;
            s3_be_reg  <= be_next;
            s3_cd_reg  <= cd_next;
            s3_ae_reg  <= ae_next;
            s3_bd_reg  <= bd_next;
            s3_a_reg   <= s2_a_reg;
            s3_b_reg   <= s2_b_reg;
            s3_c_reg   <= s2_c_reg;
            s3_d_reg   <= s2_d_reg;
            s3_e_reg   <= s2_e_reg;
            s3_ux_reg  <= s2_ux_reg;
            s3_uy_reg  <= s2_uy_reg;
            s3_vx_reg  <= s2_vx_reg;
            s3_vy_reg  <= s2_vy_reg;
            s3_wx_reg  <= s2_wx_reg;
            s3_wy_reg  <= s2_wy_reg;
            s3_rsq_reg <= s2_rsq_reg;

            s4_det_reg       <= s3_ac_reg - s3_bb_reg;
            s4_sn_reg        <= s3_be_reg - s3_cd_reg;
            s4_tn_reg        <= s3_ae_reg - s3_bd_reg;
            s4_a_reg         <= s3_a_reg;
            s4_b_reg         <= s3_b_reg;
            s4_c_reg         <= s3_c_reg;
            s4_e_reg         <= s3_e_reg;
            s4_nd_reg        <= nd_next;
            s4_bmd_reg       <= bmd_next;
            s4_nd_lt0_reg    <= nd_next < 0;
            s4_nd_gt_a_reg   <= nd_next > (DW2 + 1)'(s3_a_reg);
            s4_bmd_lt0_reg   <= bmd_next < 0;
            s4_bmd_gt_a_reg  <= bmd_next > (DW2 + 1)'(s3_a_reg);
            s4_ux_reg        <= s3_ux_reg;
            s4_uy_reg        <= s3_uy_reg;
            s4_vx_reg        <= s3_vx_reg;
            s4_vy_reg        <= s3_vy_reg;
            s4_wx_reg        <= s3_wx_reg;
            s4_wy_reg        <= s3_wy_reg;
            s4_rsq_reg       <= s3_rsq_reg;

            s5_sn_reg        <= sn5_next;
            s5_sd_reg        <= sd5_next;
            s5_tn_reg        <= tn5_next;
            s5_td_reg        <= td5_next;
            s5_a_reg         <= s4_a_reg;
            s5_nd_reg        <= s4_nd_reg;
            s5_bmd_reg       <= s4_bmd_reg;
            s5_nd_lt0_reg    <= s4_nd_lt0_reg;
            s5_nd_gt_a_reg   <= s4_nd_gt_a_reg;
            s5_bmd_lt0_reg   <= s4_bmd_lt0_reg;
            s5_bmd_gt_a_reg  <= s4_bmd_gt_a_reg;
            s5_ux_reg        <= s4_ux_reg;
            s5_uy_reg        <= s4_uy_reg;
            s5_vx_reg        <= s4_vx_reg;
            s5_vy_reg        <= s4_vy_reg;
            s5_wx_reg        <= s4_wx_reg;
            s5_wy_reg        <= s4_wy_reg;
            s5_rsq_reg       <= s4_rsq_reg;

            s6_sn_reg  <= sn6_next;
            s6_sd_reg  <= sd6_next;
            s6_tn_reg  <= tn6_next;
            s6_td_reg  <= td6_next;
            s6_ux_reg  <= s5_ux_reg;
            s6_uy_reg  <= s5_uy_reg;
            s6_vx_reg  <= s5_vx_reg;
            s6_vy_reg  <= s5_vy_reg;
            s6_wx_reg  <= s5_wx_reg;
            s6_wy_reg  <= s5_wy_reg;
            s6_rsq_reg <= s5_rsq_reg;

            s7_s_mode_reg <= s_mode_next;
            s7_t_mode_reg <= t_mode_next;
            s7_sn_reg     <= s6_sn_reg;
            s7_sd_reg     <= s6_sd_reg;
            s7_tn_reg     <= s6_tn_reg;
            s7_td_reg     <= s6_td_reg;
            s7_ux_reg     <= s6_ux_reg;
            s7_uy_reg     <= s6_uy_reg;
            s7_vx_reg     <= s6_vx_reg;
            s7_vy_reg     <= s6_vy_reg;
            s7_wx_reg     <= s6_wx_reg;
            s7_wy_reg     <= s6_wy_reg;
            s7_rsq_reg    <= s6_rsq_reg;
        end
    end

    assign out_valid  = v_reg[NST-1];
    assign out_s_mode = s7_s_mode_reg;
    assign out_t_mode = s7_t_mode_reg;
    assign out_sn     = s7_sn_reg;
    assign out_sd     = s7_sd_reg;
    assign out_tn     = s7_tn_reg;
    assign out_td     = s7_td_reg;
    assign out_ux     = s7_ux_reg;
    assign out_uy     = s7_uy_reg;
    assign out_vx     = s7_vx_reg;
    assign out_vy     = s7_vy_reg;
    assign out_wx     = s7_wx_reg;
    assign out_wy     = s7_wy_reg;
    assign out_rsq    = s7_rsq_reg;
endmodule
`default_nettype wire

/* sv/cssw_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module cssw_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    import cssw_pkg::*;

    localparam int PB = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PB-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PB:0]      count_reg;
    logic             push, pop;

    assign in_ready  = count_reg != (PB + 1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PB + 1)'(QUEUE_DEPTH))
        else $error("queue count past depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");
`endif
endmodule
`default_nettype wire

/* sv/cssw_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module cssw_div #(
    parameter int DW = 40
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  cssw_pkg::frac_mode_t              mode,
    input  wire logic [DW-1:0]                num,
    input  wire logic [DW-1:0]                den,
    output logic [cssw_pkg::FRAC_BITS:0]      frac
);
    import cssw_pkg::*;

    logic [DW-1:0]        r_reg [FRAC_BITS];
    logic [DW-1:0]        d_reg [FRAC_BITS];
    logic [FRAC_BITS-1:0] q_reg [FRAC_BITS];
    frac_mode_t           m_reg [FRAC_BITS];

    // one quotient bit per stage
    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
        logic [DW-1:0]        rp, dp;
        logic [FRAC_BITS-1:0] qp;
        frac_mode_t           mp;
        logic [DW:0]          r2;

        if (k == 0) begin : g_first
            assign rp = num;
            assign dp = den;
            assign qp = '0;
            assign mp = mode;
        end
        else begin : g_rest
            assign rp = r_reg[k-1];
            assign dp = d_reg[k-1];
            assign qp = q_reg[k-1];
            assign mp = m_reg[k-1];
        end

        assign r2 = {rp, 1'b0};

        always_ff @(posedge clk) begin
            if (en) begin
                if (r2 >= {1'b0, dp}) begin
                    r_reg[k] <= DW'(r2 - {1'b0, dp});
                    q_reg[k] <= {qp[FRAC_BITS-2:0], 1'b1};
                end
                else begin
                    r_reg[k] <= r2[DW-1:0];
                    q_reg[k] <= {qp[FRAC_BITS-2:0], 1'b0};
                end
                d_reg[k] <= dp;
                m_reg[k] <= mp;
            end
        end
    end

    always_comb begin
        unique case (m_reg[FRAC_BITS-1])
            FRAC_ONE: frac = {1'b1, {FRAC_BITS{1'b0}}};
            FRAC_DIV: frac = {1'b0, q_reg[FRAC_BITS-1]};
            default:  frac = '0;
        endcase
    end
endmodule
`default_nettype wire

/* sv/cssw_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module cssw_back #(
    parameter int COORD_BITS = cssw_pkg::COORD_BITS_DEF
) (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire logic                                              in_valid,
    output logic                                                   in_ready,
    input  cssw_pkg::frac_mode_t                                   in_s_mode,
    input  cssw_pkg::frac_mode_t                                   in_t_mode,
    input  wire logic signed [cssw_pkg::wide_bits(COORD_BITS)-1:0] in_sn,
    input  wire logic signed [cssw_pkg::wide_bits(COORD_BITS)-1:0] in_sd,
    input  wire logic signed [cssw_pkg::wide_bits(COORD_BITS)-1:0] in_tn,
    input  wire logic signed [cssw_pkg::wide_bits(COORD_BITS)-1:0] in_td,
    input  wire logic signed [COORD_BITS:0]                        in_ux,
    input  wire logic signed [COORD_BITS:0]                        in_uy,
    input  wire logic signed [COORD_BITS:0]                        in_vx,
    input  wire logic signed [COORD_BITS:0]                        in_vy,
    input  wire logic signed [COORD_BITS:0]                        in_wx,
    input  wire logic signed [COORD_BITS:0]                        in_wy,
    input  wire logic [cssw_pkg::RSQ_BITS-1:0]                     in_rsq,
    output logic                                                   out_valid,
    input  wire logic                                              out_ready,
    output logic                                                   hit,
    output logic signed [cssw_pkg::OUT_BITS-1:0]                   hit_fraction
);
    import cssw_pkg::*;

    localparam int DW  = wide_bits(COORD_BITS);
    localparam int CW  = COORD_BITS + 1;
    localparam int SW  = FRAC_BITS + 1;
    localparam int PW  = COORD_BITS + 19;
    localparam int OW  = COORD_BITS + 20;
    localparam int XW  = COORD_BITS + 4;
    localparam int SQW = 2 * XW;

    logic                 en;
    logic [FRAC_BITS-1:0] vd_reg;
    logic                 v1_reg, v2_reg, v3_reg, out_valid_reg;

    logic signed [CW-1:0] ux_reg [FRAC_BITS];
    logic signed [CW-1:0] uy_reg [FRAC_BITS];
    logic signed [CW-1:0] vx_reg [FRAC_BITS];
    logic signed [CW-1:0] vy_reg [FRAC_BITS];
    logic signed [CW-1:0] wx_reg [FRAC_BITS];
    logic signed [CW-1:0] wy_reg [FRAC_BITS];
    logic [RSQ_BITS-1:0]  rsq_reg [FRAC_BITS];

    logic [SW-1:0]        s_frac, t_frac;

    logic signed [PW-1:0] b1_sux_reg, b1_suy_reg, b1_tvx_reg, b1_tvy_reg;
    logic signed [CW-1:0] b1_wx_reg, b1_wy_reg;
    logic [SW-1:0]        b1_s_reg;
    logic [RSQ_BITS-1:0]  b1_rsq_reg;

    logic signed [OW-1:0] oxf_next, oyf_next;
    logic signed [XW-1:0] b2_ox_reg, b2_oy_reg;
    logic [SW-1:0]        b2_s_reg;
    logic [RSQ_BITS-1:0]  b2_rsq_reg;

    logic signed [SQW-1:0] b3_sqx_reg, b3_sqy_reg;
    logic [SW-1:0]         b3_s_reg;
    logic [RSQ_BITS-1:0]   b3_rsq_reg;

    logic [SQW:0]                dist_next;
    logic                        hit_next;
    logic signed [OUT_BITS-1:0]  frac_next;
    logic                        hit_reg;
    logic signed [OUT_BITS-1:0]  frac_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    cssw_div #(.DW(DW)) u_div_s (
        .clk  (clk),
        .en   (en),
        .mode (in_s_mode),
        .num  (in_sn),
        .den  (in_sd),
        .frac (s_frac)
    );

    cssw_div #(.DW(DW)) u_div_t (
        .clk  (clk),
        .en   (en),
        .mode (in_t_mode),
        .num  (in_tn),
        .den  (in_td),
        .frac (t_frac)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vd_reg        <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            vd_reg        <= {vd_reg[FRAC_BITS-2:0], in_valid};
            v1_reg        <= vd_reg[FRAC_BITS-1];
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // hold the geometry alongside the dividers
    always_ff @(posedge clk) begin
        if (en) begin
            ux_reg[0]  <= in_ux;
            uy_reg[0]  <= in_uy;
            vx_reg[0]  <= in_vx;
            vy_reg[0]  <= in_vy;
            wx_reg[0]  <= in_wx;
            wy_reg[0]  <= in_wy;
            rsq_reg[0] <= in_rsq;
            for (int i = 1; i < FRAC_BITS; i++) begin
                ux_reg[i]  <= ux_reg[i-1];
                uy_reg[i]  <= uy_reg[i-1];
                vx_reg[i]  <= vx_reg[i-1];
                vy_reg[i]  <= vy_reg[i-1];
                wx_reg[i]  <= wx_reg[i-1];
                wy_reg[i]  <= wy_reg[i-1];
                rsq_reg[i] <= rsq_reg[i-1];
            end
        end
    end

    assign oxf_next = (OW'(b1_wx_reg) <<< FRAC_BITS) + OW'(b1_sux_reg) - OW'(b1_tvx_reg);
    assign oyf_next = (OW'(b1_wy_reg) <<< FRAC_BITS) + OW'(b1_suy_reg) - OW'(b1_tvy_reg);

    assign dist_next = $unsigned((SQW + 1)'(b3_sqx_reg) + (SQW + 1)'(b3_sqy_reg));
    assign hit_next  = dist_next < (SQW + 1)'(b3_rsq_reg);
    assign frac_next = hit_next
                     ? $signed(OUT_BITS'(b3_s_reg >> FRAC_SHIFT)) - OUT_BITS'(1)
                     : OUT_BITS'(NO_HIT);

    always_ff @(posedge clk) begin
        if (en) begin
            b1_sux_reg <= $signed({1'b0, s_frac}) * ux_reg[FRAC_BITS-1];
            b1_suy_reg <= $signed({1'b0, s_frac}) * uy_reg[FRAC_BITS-1];
            b1_tvx_reg <= $signed({1'b0, t_frac}) * vx_reg[FRAC_BITS-1];
            b1_tvy_reg <= $signed({1'b0, t_frac}) * vy_reg[FRAC_BITS-1];
            b1_wx_reg  <= wx_reg[FRAC_BITS-1];
            b1_wy_reg  <= wy_reg[FRAC_BITS-1];
            b1_s_reg   <= s_frac;
            b1_rsq_reg <= rsq_reg[FRAC_BITS-1];

            // arithmetic shift floors toward minus infinity
            b2_ox_reg  <= XW'(oxf_next >>> FRAC_BITS);
            b2_oy_reg  <= XW'(oyf_next >>> FRAC_BITS);
            b2_s_reg   <= b1_s_reg;
            b2_rsq_reg <= b1_rsq_reg;

            b3_sqx_reg <= b2_ox_reg * b2_ox_reg;
            b3_sqy_reg <= b2_oy_reg * b2_oy_reg;
            b3_s_reg   <= b2_s_reg;
            b3_rsq_reg <= b2_rsq_reg;

            hit_reg    <= hit_next;
            frac_reg   <= frac_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_fraction = frac_reg;

`ifndef SYNTH
    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> frac_reg == OUT_BITS'(NO_HIT))
        else $error("miss without no-hit code");
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> (frac_reg >= -1 && frac_reg < NO_HIT))
        else $error("hit fraction out of range");
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && en) |=> vd_reg[0])
        else $error("accepted beat lost at divider entry");
`endif
endmodule
`default_nettype wire

/* test/capsule_segment_sweep_test_top_tb.sv */
`timescale 1ns / 1ps
module capsule_segment_sweep_test_top_tb;
    import cssw_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int RANDOM_TESTS = 1830;

    typedef struct {
        logic [CB-1:0] p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
        logic [RSQ_BITS-1:0] rsq;
    } sweep_test_t;

    typedef struct {
        logic hit;
        logic signed [OUT_BITS-1:0] frac;
    } sweep_result_t;

    class sweep_scoreboard;
        sweep_result_t pending[$];
        int errors;
        int checked;
        int hits;

        function longint frac_of(longint num, longint den);
            longint r;
            longint q;
            if (num <= 0 || den <= 0)
                return 0;
            if (num >= den)
                return longint'(1) << FRAC_BITS;
            r = num;
            q = 0;
            for (int k = 0; k < FRAC_BITS; k++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        function void note_test(sweep_test_t tst);
            longint ux, uy, vx, vy, wx, wy, a, b, c, d, e, det;
            longint sn, sd, tn, td, s, t, ox, oy, dist_sq;
            sweep_result_t r;
            ux = longint'(tst.p1x) - longint'(tst.p0x);
            uy = longint'(tst.p1y) - longint'(tst.p0y);
            vx = longint'(tst.q1x) - longint'(tst.q0x);
            vy = longint'(tst.q1y) - longint'(tst.q0y);
            wx = longint'(tst.p0x) - longint'(tst.q0x);
            wy = longint'(tst.p0y) - longint'(tst.q0y);
            a = ux * ux + uy * uy;
            b = ux * vx + uy * vy;
            c = vx * vx + vy * vy;
            d = ux * wx + uy * wy;
            e = vx * wx + vy * wy;
            det = a * c - b * b;
            sd = det;
            td = det;
            if (det <= 0)
            begin
                sn = 0;
                sd = 1;
                tn = e;
                td = c;
            end
            else
            begin
                sn = b * e - c * d;
                tn = a * e - b * d;
                if (sn < 0)
                begin
                    sn = 0;
                    tn = e;
                    td = c;
                end
                else if (sn > sd)
                begin
                    sn = sd;
                    tn = e + b;
                    td = c;
                end
            end
            if (tn < 0)
            begin
                tn = 0;
                if (-d < 0)
                    sn = 0;
                else if (-d > a)
                    sn = sd;
                else
                begin
                    sn = -d;
                    sd = a;
                end
            end
            else if (tn > td)
            begin
                tn = td;
                if (b - d < 0)
                    sn = 0;
                else if (b - d > a)
                    sn = sd;
                else
                begin
                    sn = b - d;
                    sd = a;
                end
            end
            s = frac_of(sn, sd);
            t = frac_of(tn, td);
            // arithmetic shift floors toward minus infinity
            ox = (wx * 65536 + s * ux - t * vx) >>> FRAC_BITS;
            oy = (wy * 65536 + s * uy - t * vy) >>> FRAC_BITS;
            dist_sq = ox * ox + oy * oy;
            if (dist_sq < longint'(tst.rsq))
            begin
                r.hit = 1'b1;
                r.frac = OUT_BITS'((s >>> FRAC_SHIFT) - 1);
            end
            else
            begin
                r.hit = 1'b0;
                r.frac = OUT_BITS'(NO_HIT);
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic hit_a, logic signed [OUT_BITS-1:0] frac_a);
            sweep_result_t x;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: hit=%0d frac=%0d", hit_a, frac_a);
                errors++;
                return;
            end
            x = pending.pop_front();
            checked++;
            if (hit_a) hits++;
            if (hit_a !== x.hit)
            begin
                $error("hit expected %0d actual %0d", x.hit, hit_a);
                errors++;
            end
            if (frac_a !== x.frac)
            begin
                $error("hit_fraction expected %0d actual %0d", x.frac, frac_a);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [CB-1:0] path_start_x, path_start_y, path_end_x, path_end_y;
    logic [CB-1:0] wall_start_x, wall_start_y, wall_end_x, wall_end_y;
    logic [RSQ_BITS-1:0] radius_squared;
    logic out_valid;
    logic out_ready;
    logic hit;
    logic signed [OUT_BITS-1:0] hit_fraction;

    sweep_scoreboard sb;
    bit sending_done;
    int sent;

    capsule_segment_sweep_test_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .path_start_x(path_start_x), .path_start_y(path_start_y),
        .path_end_x(path_end_x), .path_end_y(path_end_y),
        .wall_start_x(wall_start_x), .wall_start_y(wall_start_y),
        .wall_end_x(wall_end_x), .wall_end_y(wall_end_y),
        .radius_squared(radius_squared),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .hit_fraction(hit_fraction)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CB-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CB'($urandom_range(0, 15));
            3: return CB'($urandom_range(2032, 2047));
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic sweep_test_t random_test();
        sweep_test_t t;
        int dx, dy;
        t.p0x = pick_coord();
        t.p0y = pick_coord();
        t.p1x = pick_coord();
        t.p1y = pick_coord();
        t.q0x = pick_coord();
        t.q0y = pick_coord();
        t.q1x = pick_coord();
        t.q1y = pick_coord();
        case ($urandom_range(0, 4))
            0:
            begin
                // wall near the path, parallel or crossing
                dx = $urandom_range(0, 40) - 20;
                dy = $urandom_range(0, 40) - 20;
                t.q0x = t.p0x + CB'(dx);
                t.q0y = t.p0y + CB'(dy);
                if ($urandom_range(0, 1))
                begin
                    t.q1x = t.p1x + CB'(dx);
                    t.q1y = t.p1y + CB'(dy);
                end
            end
            1:
            begin
                t.p0x = CB'($urandom_range(900, 1100));
                t.p0y = CB'($urandom_range(900, 1100));
                t.p1x = CB'($urandom_range(900, 1100));
                t.p1y = CB'($urandom_range(900, 1100));
                t.q0x = CB'($urandom_range(900, 1100));
                t.q0y = CB'($urandom_range(900, 1100));
            end
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: t.rsq = RSQ_BITS'($urandom);
            1: t.rsq = RSQ_BITS'($urandom_range(0, 4096));
            2: t.rsq = '1;
            default: t.rsq = RSQ_BITS'($urandom_range(0, 200000));
        endcase
        return t;
    endfunction

    task automatic send_test(sweep_test_t t);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (sent > 600 && sent < 800)
            gap = 0;
        // drop valid only when idling, so back-to-back beats keep it high
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        path_start_x <= t.p0x;
        path_start_y <= t.p0y;
        path_end_x <= t.p1x;
        path_end_y <= t.p1y;
        wall_start_x <= t.q0x;
        wall_start_y <= t.q0y;
        wall_end_x <= t.q1x;
        wall_end_y <= t.q1y;
        radius_squared <= t.rsq;
        do @(posedge clk); while (!in_ready);
        sb.note_test(t);
        sent++;
    endtask

    function automatic sweep_test_t make_test(int p0x, int p0y, int p1x, int p1y,
                                              int q0x, int q0y, int q1x, int q1y,
                                              int rsq);
        sweep_test_t t;
        t.p0x = CB'(p0x); t.p0y = CB'(p0y); t.p1x = CB'(p1x); t.p1y = CB'(p1y);
        t.q0x = CB'(q0x); t.q0y = CB'(q0y); t.q1x = CB'(q1x); t.q1y = CB'(q1y);
        t.rsq = RSQ_BITS'(rsq);
        return t;
    endfunction

    initial
    begin
        sweep_test_t dir[$];
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {path_start_x, path_start_y, path_end_x, path_end_y} = '0;
        {wall_start_x, wall_start_y, wall_end_x, wall_end_y} = '0;
        radius_squared = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // all zero, all max, crossing, parallel, degenerate, endpoints clamp
        dir.push_back(make_test(0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_test(0, 0, 0, 0, 0, 0, 0, 0, 1));
        dir.push_back(make_test(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 1048575));
        dir.push_back(make_test(0, 0, 2047, 2047, 0, 2047, 2047, 0, 1048575));
        dir.push_back(make_test(0, 0, 2047, 2047, 0, 2047, 2047, 0, 0));
        dir.push_back(make_test(0, 0, 2047, 0, 0, 10, 2047, 10, 101));
        dir.push_back(make_test(0, 0, 2047, 0, 0, 10, 2047, 10, 100));
        dir.push_back(make_test(0, 0, 100, 0, 200, 5, 300, 5, 1048575));
        dir.push_back(make_test(100, 0, 0, 0, 200, 5, 300, 5, 1048575));
        dir.push_back(make_test(500, 500, 500, 500, 400, 400, 600, 600, 4));
        dir.push_back(make_test(0, 0, 1000, 0, 300, 300, 300, 300, 1048575));
        dir.push_back(make_test(0, 0, 1000, 0, 500, 0, 500, 2047, 1));
        dir.push_back(make_test(0, 0, 1000, 0, 1200, 100, 1300, -100, 50000));
        dir.push_back(make_test(0, 0, 1000, 0, -200, 100, -100, -100, 50000));
        dir.push_back(make_test(0, 0, 2047, 0, 1024, 1, 1024, 2047, 2));
        dir.push_back(make_test(2047, 0, 0, 2047, 0, 0, 2047, 2047, 1048575));
        dir.push_back(make_test(10, 10, 20, 20, 20, 20, 30, 30, 1));
        dir.push_back(make_test(10, 10, 20, 20, 30, 30, 40, 40, 1048575));
        dir.push_back(make_test(1365, 682, 682, 1365, 1023, 1024, 1024, 1023, 3));
        dir.push_back(make_test(5, 0, 5, 2047, 0, 100, 2047, 100, 1));
        foreach (dir[i]) send_test(dir[i]);
        repeat (RANDOM_TESTS) send_test(random_test());
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver: random stalls plus one long hold-off while the sender pushes
    initial
    begin
        int stall;
        bit long_done;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(hit, hit_fraction);
            if (!long_done && sent >= 620)
            begin
                long_done = 1'b1;
                stall = 150;
            end
            else if (out_valid && out_ready || !out_ready && stall == 0)
                stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        wait (sending_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("checked %0d sweep tests, %0d hits, including a long output stall",
                 sb.checked, sb.hits);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results pending", sb.pending.size());
        $display("end of test: mismatches");
        $finish;
    end
endmodule
